FILE: src/rws_pkg.sv
// Shared constants and types for the roulette wheel selection block.
`default_nettype none

package rws_pkg;

	localparam int POP_MAX      = 256;
	localparam int IDX_W        = $clog2(POP_MAX);
	localparam int CNT_W        = IDX_W + 1;
	localparam int FIT_W        = 16;
	localparam int FRAC_W       = 16;
	localparam int SUM_W        = 24;
	localparam int TGT_W        = SUM_W + FRAC_W;
	localparam int KIND_W       = 2;

	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// Request from the top level to the draw sequencer.
	typedef struct packed {
		logic              start;
		logic [FRAC_W-1:0] frac;
		logic [SUM_W-1:0]  total;
		logic [IDX_W-1:0]  last;
	} draw_req_t;

	// Status returned by the draw sequencer.
	typedef struct packed {
		logic             idle;
		logic             done;
		logic [IDX_W-1:0] index;
	} draw_res_t;

endpackage

`default_nettype wire

FILE: src/rws_ram.sv
// Prefix sum store: one write port, one read port with registered read data.
`default_nettype none

module rws_ram
	import rws_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire logic [SUM_W-1:0] wdata,
	input  wire logic [IDX_W-1:0] raddr,
	output logic      [SUM_W-1:0] rdata
);

	logic [SUM_W-1:0] mem [POP_MAX];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: src/rws_draw.sv
// Draw sequencer: forms the target once, then walks the prefix sums with one compare a cycle.
`default_nettype none

module rws_draw
	import rws_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire draw_req_t        req,
	input  wire logic [SUM_W-1:0] rd_data,
	output logic      [IDX_W-1:0] rd_addr,
	output draw_res_t             res
);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_MUL  = 3'b010,
		D_SCAN = 3'b100
	} draw_state_t;

	draw_state_t      state_q;
	logic [FRAC_W-1:0] frac_q;
	logic [SUM_W-1:0]  total_q;
	logic [IDX_W-1:0]  last_q;
	logic [TGT_W-1:0]  target_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  index_q;
	logic              done_q;
	logic              hit;

	// The entry read last cycle belongs to idx_q; stop at the first one that reaches the target, or at the last entry.
	assign hit = ({rd_data, {FRAC_W{1'b0}}} >= target_q) || (idx_q == last_q);

	always_comb begin
		case (state_q)
			D_SCAN:  rd_addr = idx_q + IDX_W'(1);
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						state_q <= D_MUL;
					end
				end
				D_MUL: begin
					if (total_q == '0) begin
						state_q <= D_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= D_SCAN;
					end
				end
				D_SCAN: begin
					if (hit) begin
						state_q <= D_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (req.start) begin
					frac_q  <= req.frac;
					total_q <= req.total;
					last_q  <= req.last;
				end
			end
			D_MUL: begin
				target_q <= TGT_W'(frac_q) * TGT_W'(total_q);
				idx_q    <= '0;
				index_q  <= '0;
			end
			D_SCAN: begin
				if (hit) begin
					index_q <= idx_q;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign res.idle  = (state_q == D_IDLE);
	assign res.done  = done_q;
	assign res.index = index_q;

endmodule

`default_nettype wire

FILE: src/roulette_wheel_selection.sv
// Top level of the fitness-proportionate roulette wheel selection block.
//
// Usage. Input words arrive on in_valid / in_ready with a kind code. A clear word
// restarts loading and clears the overflow indication. A load word appends one
// fitness value: its running prefix sum is written to the prefix store and the
// total is kept, saturating at the largest 24-bit value. Loads beyond the store's
// capacity are dropped and raise the overflow indication. A draw word carries a
// Q0.16 random fraction and produces one output word on out_valid / out_ready:
// the first entry whose prefix sum reaches fraction times total, capped at
// pop_size - 1, together with the overflow indication.
// Timing. After a clear or load word the block is ready again at once. A draw first
// forms the 40-bit target in the multiplier register, then the single comparator
// walks the prefix store entry by entry behind the RAM's registered read port;
// the found index is registered in the sequencer with its done flag and then in the
// output register. The scan is skipped when the total is zero. The block takes no
// input word while a draw is in progress. Reset clears the loaded count, the total,
// the overflow indication and pop_size returns to 256; the prefix store itself is
// not cleared and needs no clearing pass. A stalled receiver holds the result in
// the output register; clears and loads are still taken meanwhile, but a further
// draw waits until the result has been taken. The user must write pop_size through
// cfg_we / cfg_data while the block is idle; the block itself does not enforce this.
`default_nettype none

module roulette_wheel_selection
	import rws_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CNT_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic [FIT_W-1:0]  fitness_value,
	input  wire logic [FRAC_W-1:0] random_fraction,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [IDX_W-1:0]  selected_index,
	output logic                   overflow_flag
);

	logic [CNT_W-1:0] pop_size_q;
	logic [CNT_W-1:0] loaded_q;
	logic [SUM_W-1:0] total_q;
	logic             ovf_seen_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] sel_q;
	logic             sel_ovf_q;

	logic             accept;
	logic             full;
	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_sat;
	logic             ram_we;
	logic [SUM_W-1:0] rd_data;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] last_idx;
	draw_req_t        req;
	draw_res_t        res;

	// A draw needs a free output register, and none may be about to land in it from
	// the sequencer; other words only need the sequencer idle.
	assign in_ready = res.idle && !((out_valid_q || res.done) && (kind == KIND_DRAW));
	assign accept   = in_valid && in_ready;

	assign full     = (loaded_q == CNT_W'(POP_MAX));
	assign sum_wide = {1'b0, total_q} + (SUM_W+1)'(fitness_value);
	assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
	assign ram_we   = accept && (kind == KIND_LOAD) && !full;

	// A pop_size of zero searches one entry; anything above capacity searches all.
	always_comb begin
		if (pop_size_q == '0) begin
			last_idx = '0;
		end else if (pop_size_q > CNT_W'(POP_MAX)) begin
			last_idx = IDX_W'(POP_MAX - 1);
		end else begin
			last_idx = IDX_W'(pop_size_q - CNT_W'(1));
		end
	end

	assign req.start = accept && (kind == KIND_DRAW);
	assign req.frac  = random_fraction;
	assign req.total = total_q;
	assign req.last  = last_idx;

	rws_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (loaded_q[IDX_W-1:0]),
		.wdata (sum_sat),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	rws_draw u_draw (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data),
		.rd_addr (rd_addr),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_size_q  <= CNT_W'(POP_MAX);
			loaded_q    <= '0;
			total_q     <= '0;
			ovf_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pop_size_q <= cfg_data;
			end
			if (accept) begin
				case (kind)
					KIND_CLEAR: begin
						loaded_q   <= '0;
						total_q    <= '0;
						ovf_seen_q <= 1'b0;
					end
					KIND_LOAD: begin
						if (full) begin
							ovf_seen_q <= 1'b1;
						end else begin
							total_q  <= sum_sat;
							loaded_q <= loaded_q + CNT_W'(1);
						end
					end
					default: ;
				endcase
			end
			if (res.done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The overflow indication is sampled when the draw finishes; no word is taken in between.
	always_ff @(posedge clk) begin
		if (res.done) begin
			sel_q     <= res.index;
			sel_ovf_q <= ovf_seen_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign selected_index = sel_q;
	assign overflow_flag  = sel_ovf_q;

endmodule

`default_nettype wire

FILE: src/rws_checker.sv
// Port-level checks for the roulette wheel selection block, bound to the top level.
`default_nettype none

module rws_checker
	import rws_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic [KIND_W-1:0] kind,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [IDX_W-1:0]  selected_index,
	input wire logic              overflow_flag
);

	// A held result word keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(selected_index) &&
			$stable(overflow_flag))
		else $error("result word changed while stalled");

	// Once a draw is taken the block is busy for at least the next cycle.
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_DRAW |=> !in_ready)
		else $error("input taken during a draw");

	// No result can appear in the cycle straight after a draw is taken.
	a_draw_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_DRAW |=> !out_valid)
		else $error("result appeared too early");

	// A new result only ever follows a draw: the block was busy with it before the result shows.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready, 2))
		else $error("result without a draw in progress");

endmodule

bind roulette_wheel_selection rws_checker u_rws_checker (.*);

`default_nettype wire
